@@ rtl/core/ltd_pkg.sv @@
// Shared types and constants of the LZSS token decoder.
package ltd_pkg;

    localparam int HIST_DEPTH  = 65536;
    localparam int HIST_AW     = 16;
    localparam int STAGE_DEPTH = 258;
    localparam int STAGE_AW    = 9;
    localparam int LEN_W       = 9;
    localparam int POS_W       = 3;
    localparam int BEAT_W      = 64;
    localparam int COUNT_W     = 4;

    typedef struct packed {
        logic lit_write;
        logic end_emit;
        logic load_len;
        logic load_off_lo;
        logic start_match;
        logic rd_issue;
        logic wb_start;
        logic wb_issue;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic idx_end;
        logic issue_flush;
    } status_t;

endpackage

@@ rtl/core/ltd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ltd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/ltd_ctrl.sv @@
// Token parser and match sequencer of the LZSS token decoder.
module ltd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  ltd_pkg::status_t status,
    output ltd_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_COPY  = 3'b010,
        ST_WBACK = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        PH_TOKEN  = 2'd0,
        PH_OFF_LO = 2'd1,
        PH_OFF_HI = 2'd2
    } phase_t;

    localparam logic [2:0] TOKENS_NONE = 3'd0;
    localparam logic [2:0] TOKENS_MAX  = 3'd5;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [2:0] tokens_reg, tokens_next;
    logic [7:0] flags_reg, flags_next;
    logic       stopped_reg, stopped_next;
    logic [2:0] hdr_count;
    logic       accept;

    assign hdr_count = in_byte[7:5];
    assign in_ready  = (state_reg == ST_IDLE) && (stopped_reg || status.out_free);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        phase_next   = phase_reg;
        tokens_next  = tokens_reg;
        flags_next   = flags_reg;
        stopped_next = stopped_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !stopped_reg)
                begin
                    unique case (phase_reg)
                        PH_OFF_LO:
                        begin
                            cmd.load_off_lo = 1'b1;
                            phase_next      = PH_OFF_HI;
                        end
                        PH_OFF_HI:
                        begin
                            cmd.start_match = 1'b1;
                            state_next      = ST_COPY;
                            phase_next      = PH_TOKEN;
                            flags_next      = {flags_reg[6:0], 1'b0};
                            if (tokens_reg != TOKENS_NONE)
                            begin
                                tokens_next = tokens_reg - 3'd1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_TOKEN;
                            if (tokens_reg == TOKENS_NONE)
                            begin
                                if (hdr_count == TOKENS_NONE || hdr_count > TOKENS_MAX)
                                begin
                                    cmd.end_emit = 1'b1;
                                    stopped_next = 1'b1;
                                end
                                else
                                begin
                                    tokens_next = hdr_count;
                                    flags_next  = {in_byte[4:0], 3'b000};
                                end
                            end
                            else if (flags_reg[7])
                            begin
                                cmd.lit_write = 1'b1;
                                flags_next    = {flags_reg[6:0], 1'b0};
                                tokens_next   = tokens_reg - 3'd1;
                            end
                            else
                            begin
                                cmd.load_len = 1'b1;
                                phase_next   = PH_OFF_LO;
                            end
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                if (status.idx_end)
                begin
                    cmd.wb_start = 1'b1;
                    state_next   = ST_WBACK;
                end
                else if (!status.issue_flush || status.out_free)
                begin
                    cmd.rd_issue = 1'b1;
                end
            end
            ST_WBACK:
            begin
                if (status.idx_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.wb_issue = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_TOKEN;
            tokens_reg  <= '0;
            flags_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            tokens_reg  <= tokens_next;
            flags_reg   <= flags_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

@@ rtl/core/ltd_datapath.sv @@
// History, copy stage, beat packer and output register of the LZSS token decoder.
module ltd_datapath #(
    parameter int MIN_MATCH  = 3,
    parameter int BEAT_BYTES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [7:0]                    in_byte,
    input  ltd_pkg::cmd_t                 cmd,
    output ltd_pkg::status_t              status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [ltd_pkg::BEAT_W-1:0]    out_bytes,
    output logic [ltd_pkg::COUNT_W-1:0]   out_count,
    output logic                          out_last,
    output logic                          out_end
);

    localparam logic [ltd_pkg::POS_W-1:0] POS_LAST = ltd_pkg::POS_W'(BEAT_BYTES - 1);

    logic [ltd_pkg::HIST_AW-1:0]   wp_reg, wp_next;
    logic                          wrapped_reg, wrapped_next;
    logic [ltd_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [7:0]                    off_lo_reg, off_lo_next;
    logic [ltd_pkg::HIST_AW-1:0]   src_reg, src_next;
    logic [ltd_pkg::STAGE_AW-1:0]  idx_reg, idx_next;
    logic [ltd_pkg::POS_W-1:0]     ipos_reg, ipos_next;
    logic [ltd_pkg::BEAT_W-1:0]    beat_reg, beat_next;
    logic                          rdv_reg, rdv_next;
    logic [ltd_pkg::POS_W-1:0]     rd_pos_reg, rd_pos_next;
    logic                          rd_flush_reg, rd_flush_next;
    logic                          rd_final_reg, rd_final_next;
    logic                          rd_hit_reg, rd_hit_next;
    logic [ltd_pkg::STAGE_AW-1:0]  rd_sidx_reg, rd_sidx_next;
    logic                          wbv_reg, wbv_next;
    logic                          out_valid_reg, out_valid_next;
    logic [ltd_pkg::BEAT_W-1:0]    out_bytes_reg, out_bytes_next;
    logic [ltd_pkg::COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_end_reg, out_end_next;

    logic [ltd_pkg::HIST_AW-1:0]   hist_raddr;
    logic [7:0]                    hist_rdata;
    logic                          hist_we;
    logic [7:0]                    hist_wdata;
    logic [7:0]                    stage_rdata;
    logic [7:0]                    rd_byte;
    logic [ltd_pkg::BEAT_W-1:0]    beat_acc;
    logic                          last_idx;
    logic                          flush_now;
    logic                          wp_inc;

    assign hist_raddr = src_reg + ltd_pkg::HIST_AW'(idx_reg);
    assign last_idx   = (idx_reg == len_reg - ltd_pkg::LEN_W'(1));
    assign flush_now  = (ipos_reg == POS_LAST) || last_idx;
    assign rd_byte    = rd_hit_reg ? hist_rdata : 8'h00;
    assign beat_acc   = beat_reg
                      | ({{(ltd_pkg::BEAT_W-8){1'b0}}, rd_byte} << {rd_pos_reg, 3'b000});
    assign hist_we    = cmd.lit_write || wbv_reg;
    assign hist_wdata = cmd.lit_write ? in_byte : stage_rdata;
    assign wp_inc     = hist_we;

    assign status.out_free    = (!out_valid_reg || out_ready) && !(rdv_reg && rd_flush_reg);
    assign status.idx_end     = (idx_reg == len_reg);
    assign status.issue_flush = flush_now;

    ltd_ram #(
        .WIDTH (8),
        .DEPTH (ltd_pkg::HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wp_reg),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    ltd_ram #(
        .WIDTH (8),
        .DEPTH (ltd_pkg::STAGE_DEPTH)
    ) u_stage (
        .clk   (clk),
        .we    (rdv_reg),
        .waddr (rd_sidx_reg),
        .wdata (rd_byte),
        .raddr (idx_reg),
        .rdata (stage_rdata)
    );

    always_comb
    begin
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        len_next       = len_reg;
        off_lo_next    = off_lo_reg;
        src_next       = src_reg;
        idx_next       = idx_reg;
        ipos_next      = ipos_reg;
        beat_next      = beat_reg;
        rdv_next       = 1'b0;
        rd_pos_next    = rd_pos_reg;
        rd_flush_next  = rd_flush_reg;
        rd_final_next  = rd_final_reg;
        rd_hit_next    = rd_hit_reg;
        rd_sidx_next   = rd_sidx_reg;
        wbv_next       = cmd.wb_issue;
        out_valid_next = out_valid_reg && !out_ready;
        out_bytes_next = out_bytes_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        out_end_next   = out_end_reg;

        if (wp_inc)
        begin
            wp_next = wp_reg + ltd_pkg::HIST_AW'(1);
            if (&wp_reg)
            begin
                wrapped_next = 1'b1;
            end
        end

        if (cmd.load_len)
        begin
            len_next = ltd_pkg::LEN_W'(in_byte) + ltd_pkg::LEN_W'(MIN_MATCH);
        end

        if (cmd.load_off_lo)
        begin
            off_lo_next = in_byte;
        end

        if (cmd.start_match)
        begin
            src_next  = wp_reg + {in_byte, off_lo_reg};
            idx_next  = '0;
            ipos_next = '0;
            beat_next = '0;
        end

        if (cmd.rd_issue)
        begin
            idx_next      = idx_reg + ltd_pkg::STAGE_AW'(1);
            ipos_next     = (ipos_reg == POS_LAST) ? '0 : ipos_reg + ltd_pkg::POS_W'(1);
            rdv_next      = 1'b1;
            rd_pos_next   = ipos_reg;
            rd_flush_next = flush_now;
            rd_final_next = last_idx;
            rd_hit_next   = wrapped_reg || (hist_raddr < wp_reg);
            rd_sidx_next  = idx_reg;
        end

        if (cmd.wb_start)
        begin
            idx_next = '0;
        end

        if (cmd.wb_issue)
        begin
            idx_next = idx_reg + ltd_pkg::STAGE_AW'(1);
        end

        if (rdv_reg)
        begin
            if (rd_flush_reg)
            begin
                beat_next      = '0;
                out_valid_next = 1'b1;
                out_bytes_next = beat_acc;
                out_count_next = ltd_pkg::COUNT_W'(rd_pos_reg) + ltd_pkg::COUNT_W'(1);
                out_last_next  = rd_final_reg;
                out_end_next   = 1'b0;
            end
            else
            begin
                beat_next = beat_acc;
            end
        end

        if (cmd.lit_write)
        begin
            out_valid_next = 1'b1;
            out_bytes_next = {{(ltd_pkg::BEAT_W-8){1'b0}}, in_byte};
            out_count_next = ltd_pkg::COUNT_W'(1);
            out_last_next  = 1'b1;
            out_end_next   = 1'b0;
        end

        if (cmd.end_emit)
        begin
            out_valid_next = 1'b1;
            out_bytes_next = '0;
            out_count_next = '0;
            out_last_next  = 1'b1;
            out_end_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            idx_reg       <= '0;
            rdv_reg       <= 1'b0;
            wbv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            idx_reg       <= idx_next;
            rdv_reg       <= rdv_next;
            wbv_reg       <= wbv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        off_lo_reg    <= off_lo_next;
        src_reg       <= src_next;
        ipos_reg      <= ipos_next;
        beat_reg      <= beat_next;
        rd_pos_reg    <= rd_pos_next;
        rd_flush_reg  <= rd_flush_next;
        rd_final_reg  <= rd_final_next;
        rd_hit_reg    <= rd_hit_next;
        rd_sidx_reg   <= rd_sidx_next;
        out_bytes_reg <= out_bytes_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
        out_end_reg   <= out_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_bytes = out_bytes_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;
    assign out_end   = out_end_reg;

endmodule

@@ rtl/core/lzss_token_decoder.sv @@
// Top level of the LZSS token decoder: token parser, match copy engine and beat output.
//
// The slave stream takes one token byte per word (header, literal, length or offset byte).
// The master stream returns decoded bytes in words of up to BEAT_BYTES bytes; tlast marks
// the final word caused by one input byte and tuser marks the end-of-stream word.
// Header, length and low offset bytes return nothing; a header with a token count of zero
// or above five ends the stream instead. A literal's word is valid on the next cycle.
// A match reads the 64 KiB history into a 258-byte copy stage, sending each word as it
// fills, then writes the stage back into history. No input is taken during a match.
// The master side has one output register; input is taken only while that register is
// empty or its word is taken in the same cycle. A stalled receiver stalls the
// copy at word boundaries and holds the slave side.
// Reset clears the parser and the write pointer. History entries not yet written read as
// zero, tracked by the write pointer and a wrap flag, so no clearing pass is needed.
// After the end-of-stream word every input word is taken and dropped until reset.
module lzss_token_decoder #(
    parameter int MIN_MATCH  = 3,
    parameter int BEAT_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] out_bytes, [67:64] out_count, [71:68] zero
    output logic        m_tlast,   // last_beat
    output logic        m_tuser    // stream_end
);

    ltd_pkg::cmd_t                  cmd;
    ltd_pkg::status_t               status;
    logic [ltd_pkg::BEAT_W-1:0]     out_bytes;
    logic [ltd_pkg::COUNT_W-1:0]    out_count;

    ltd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .status   (status),
        .cmd      (cmd)
    );

    ltd_datapath #(
        .MIN_MATCH  (MIN_MATCH),
        .BEAT_BYTES (BEAT_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_bytes (out_bytes),
        .out_count (out_count),
        .out_last  (m_tlast),
        .out_end   (m_tuser)
    );

    assign m_tdata = {4'b0000, out_count, out_bytes};

    a_lit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.lit_write || cmd.end_emit) |-> status.out_free)
        else $error("word loaded into a busy output register");

    a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata[67:64] == 4'd0))
        else $error("end-of-stream word malformed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |->
            (m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'(BEAT_BYTES)))
        else $error("byte count out of range");

    a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tuser) |=> !m_tvalid)
        else $error("word produced after end of stream");

    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.lit_write, cmd.end_emit, cmd.load_len, cmd.load_off_lo,
                  cmd.start_match, cmd.rd_issue, cmd.wb_start, cmd.wb_issue}))
        else $error("conflicting datapath commands");

endmodule
